@@ hdl/lkvc_pkg.sv @@
package lkvc_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SDRAIN,
    S_CHECK,
    S_UPD,
    S_UDRAIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic issue;
    logic scan;
    logic upd;
    logic touch;
  } ctl_t;

endpackage

@@ hdl/lkvc_if.sv @@
interface lkvc_req_if;
  import lkvc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic signed [KEY_W-1:0] key;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, req_type, key, value, input ready);
  modport sink (input valid, req_type, key, value, output ready);
endinterface

interface lkvc_rsp_if;
  import lkvc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic signed [VAL_W-1:0] read_value;

  modport source (output valid, hit, read_value, input ready);
  modport sink (input valid, hit, read_value, output ready);
endinterface

@@ hdl/lkvc_tag_store.sv @@
module lkvc_tag_store #(
  parameter int ENTRIES = 16,
  parameter int IW = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lkvc_pkg::ctl_t           ctl,
  input  logic [IW-1:0]            raddr,
  input  logic [ENTRIES-1:0]       valid,
  input  logic [lkvc_pkg::KEY_W-1:0] key,
  input  logic [IW-1:0]            ins_slot,
  input  logic                     evict,
  output logic                     hit,
  output logic [IW-1:0]            hit_slot,
  output logic                     old_found,
  output logic [IW-1:0]            old_slot,
  output logic                     free_found,
  output logic [IW-1:0]            free_slot
);
  import lkvc_pkg::*;

  localparam int AW = IW;
  localparam int TW = KEY_W + AW;

  logic [TW-1:0]    mem [ENTRIES];
  logic [TW-1:0]    rd_q_r;
  logic [IW-1:0]    pidx_r;
  logic             pvld_r;

  logic             hit_r;
  logic [IW-1:0]    hit_slot_r;
  logic [AW-1:0]    hit_age_r;
  logic             old_f_r;
  logic [IW-1:0]    old_r;
  logic [AW-1:0]    old_age_r;
  logic             free_f_r;
  logic [IW-1:0]    free_r;

  logic [KEY_W-1:0] rd_key;
  logic [AW-1:0]    rd_age;
  logic             pv;
  logic             wen;
  logic [TW-1:0]    wdata;

  assign rd_key = rd_q_r[TW-1:AW];
  assign rd_age = rd_q_r[AW-1:0];
  assign pv     = valid[pidx_r];
  assign wen    = pvld_r && ctl.upd;

  // The update pass writes entry i while it reads entry i+1, so a read never
  // meets a write to the same entry.
  always_comb begin
    wdata = rd_q_r;
    if (ctl.touch) begin
      if (pidx_r == hit_slot_r) begin
        wdata = {rd_key, {AW{1'b0}}};
      end else if (pv && (rd_age < hit_age_r)) begin
        wdata = {rd_key, rd_age + AW'(1)};
      end
    end else begin
      if (pidx_r == ins_slot) begin
        wdata = {key, {AW{1'b0}}};
      end else if (pv && !(evict && (pidx_r == old_r))) begin
        wdata = {rd_key, rd_age + AW'(1)};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      rd_q_r <= mem[raddr];
    end
    if (wen) begin
      mem[pidx_r] <= wdata;
    end
    pidx_r <= raddr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r <= 1'b0;
    end else begin
      pvld_r <= ctl.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      hit_r      <= 1'b0;
      old_f_r    <= 1'b0;
      free_f_r   <= 1'b0;
      hit_slot_r <= '0;
      hit_age_r  <= '0;
      old_r      <= '0;
      old_age_r  <= '0;
      free_r     <= '0;
    end else if (pvld_r && ctl.scan) begin
      if (pv && (rd_key == key) && !hit_r) begin
        hit_r      <= 1'b1;
        hit_slot_r <= pidx_r;
        hit_age_r  <= rd_age;
      end
      if (pv && (!old_f_r || (rd_age > old_age_r))) begin
        old_f_r   <= 1'b1;
        old_r     <= pidx_r;
        old_age_r <= rd_age;
      end
      if (!pv && !free_f_r) begin
        free_f_r <= 1'b1;
        free_r   <= pidx_r;
      end
    end
  end

  assign hit        = hit_r;
  assign hit_slot   = hit_slot_r;
  assign old_found  = old_f_r;
  assign old_slot   = old_r;
  assign free_found = free_f_r;
  assign free_slot  = free_r;

`ifndef SYNTHESIS
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.scan && ctl.upd))
    else $error("tag store scanned and updated in the same cycle");

  a_insert_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (wen && !ctl.touch) |-> (free_f_r || evict))
    else $error("insert without a free or evicted entry");

  a_hit_stays_found: assert property (@(posedge clk) disable iff (!rst_n)
    (hit_r && !ctl.clear) |=> (hit_r && $stable(hit_slot_r)))
    else $error("hit slot changed during an item");
`endif

endmodule

@@ hdl/lru_key_value_cache.sv @@
// Each word runs as a scan pass over all ENTRIES key slots of the tag memory,
// one slot per cycle through a registered read, then, for a get that hits and
// for every put, an age update pass. A get that misses skips the update pass.
// One word is worked on at a time, and a result still held at the output delays
// the finish of the next. Synchronous active-low reset empties the cache.
module lru_key_value_cache #(
  parameter int ENTRIES = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  lkvc_req_if.sink                   in_ch,
  lkvc_rsp_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [lkvc_pkg::CAP_W-1:0] cfg_data
);
  import lkvc_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OW = $clog2(ENTRIES + 1);
  localparam int CW = (OW > CAP_W) ? OW : CAP_W;

  state_t             state_r, state_nxt;
  logic [CAP_W-1:0]   cap_r;
  logic [ENTRIES-1:0] valid_r;
  logic [OW-1:0]      occ_r;
  logic [IW-1:0]      cnt_r;

  logic               type_r;
  logic [KEY_W-1:0]   key_r;
  logic [VAL_W-1:0]   val_r;

  logic [VAL_W-1:0]   val_mem [ENTRIES];
  logic [VAL_W-1:0]   valq_r;

  logic               out_valid_r;
  logic               out_hit_r;
  logic [VAL_W-1:0]   out_val_r;

  ctl_t               ctl;
  logic               accept;
  logic               last;
  logic               done_load;
  logic               commit;

  logic               hit;
  logic [IW-1:0]      hit_slot;
  logic               old_found;
  logic [IW-1:0]      old_slot;
  logic               free_found;
  logic [IW-1:0]      free_slot;

  logic [CW-1:0]      cap_ext;
  logic [CW-1:0]      eff_cap;
  logic               full;
  logic               evict;
  logic [IW-1:0]      ins_slot;

  assign cap_ext = CW'(cap_r);
  assign eff_cap = (cap_r == '0) ? CW'(1) :
                   ((cap_ext > CW'(ENTRIES)) ? CW'(ENTRIES) : cap_ext);
  assign full    = CW'(occ_r) >= eff_cap;
  assign evict   = (type_r == REQ_PUT) && !hit && full && old_found;
  assign ins_slot = (evict && (!free_found || (old_slot < free_slot))) ? old_slot : free_slot;

  assign accept = in_ch.valid && in_ch.ready;
  assign last   = cnt_r == IW'(ENTRIES - 1);

  // The compare of the last slot lands at the end of the drain cycle, so the
  // hit decision is taken in S_CHECK, which follows it.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_ch.valid) state_nxt = S_SCAN;
      S_SCAN:   if (last) state_nxt = S_SDRAIN;
      S_SDRAIN: state_nxt = S_CHECK;
      S_CHECK:  state_nxt = (hit || (type_r == REQ_PUT)) ? S_UPD : S_DONE;
      S_UPD:    if (last) state_nxt = S_UDRAIN;
      S_UDRAIN: state_nxt = S_DONE;
      S_DONE:   if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    ctl         = '0;
    done_load   = 1'b0;
    commit      = 1'b0;
    ctl.touch   = hit;
    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        ctl.clear   = in_ch.valid;
      end
      S_SCAN: begin
        ctl.issue = 1'b1;
        ctl.scan  = 1'b1;
      end
      S_SDRAIN: ctl.scan = 1'b1;
      S_UPD: begin
        ctl.issue = 1'b1;
        ctl.upd   = 1'b1;
      end
      S_UDRAIN: begin
        ctl.upd = 1'b1;
        commit  = !hit;
      end
      S_DONE: done_load = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      cap_r   <= CAP_RESET;
    end else begin
      state_r <= state_nxt;
      if (ctl.issue) begin
        cnt_r <= last ? '0 : cnt_r + IW'(1);
      end
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      type_r <= in_ch.req_type;
      key_r  <= in_ch.key;
      val_r  <= in_ch.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
    end else if (commit) begin
      if (evict) begin
        valid_r[old_slot] <= 1'b0;
      end
      valid_r[ins_slot] <= 1'b1;
      occ_r <= evict ? occ_r : occ_r + OW'(1);
    end
  end

  always_ff @(posedge clk) begin
    valq_r <= val_mem[hit_slot];
    if ((state_r == S_UDRAIN) && (type_r == REQ_PUT)) begin
      val_mem[hit ? hit_slot : ins_slot] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_load) begin
      out_hit_r <= hit;
      if (type_r == REQ_PUT) begin
        out_val_r <= val_r;
      end else if (hit) begin
        out_val_r <= valq_r;
      end else begin
        out_val_r <= MISS_VALUE;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hit        = out_hit_r;
  assign out_ch.read_value = out_val_r;

  lkvc_tag_store #(
    .ENTRIES (ENTRIES),
    .IW      (IW)
  ) u_tag_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .raddr      (cnt_r),
    .valid      (valid_r),
    .key        (key_r),
    .ins_slot   (ins_slot),
    .evict      (evict),
    .hit        (hit),
    .hit_slot   (hit_slot),
    .old_found  (old_found),
    .old_slot   (old_slot),
    .free_found (free_found),
    .free_slot  (free_slot)
  );

`ifndef SYNTHESIS
  a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == occ_r)
    else $error("occupancy does not match the valid entries");

  a_occ_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OW'(ENTRIES))
    else $error("occupancy above the number of entries");

  a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the done state");

  a_commit_grows_safely: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && !evict) |=> (CW'(occ_r) <= eff_cap))
    else $error("insert grew occupancy past the capacity");
`endif

endmodule

@@ test/tb_lru_key_value_cache.sv @@
module tb_lru_key_value_cache;
  timeunit 1ns;
  timeprecision 1ps;

  import lkvc_pkg::*;

  localparam int SLOTS = 16;
  localparam int DRAIN_CYCLES = 2 * SLOTS + 8;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
  } reply_t;

  class lru_cache_scoreboard;
    bit               slot_valid [SLOTS];
    logic [KEY_W-1:0] slot_key   [SLOTS];
    logic [VAL_W-1:0] slot_value [SLOTS];
    int unsigned      slot_age   [SLOTS];
    int unsigned      occupancy;
    logic [CAP_W-1:0] capacity;
    reply_t           pending_replies [$];
    int               mismatches;

    function new();
      capacity = CAP_RESET;
      occupancy = 0;
      mismatches = 0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_valid[i] = 1'b0;
        slot_key[i] = '0;
        slot_value[i] = '0;
        slot_age[i] = 0;
      end
    endfunction

    function void set_capacity(logic [CAP_W-1:0] c);
      capacity = c;
    endfunction

    // Age zero is the most recent entry; every younger entry ages by one.
    function void promote(int s);
      int unsigned a;
      a = slot_age[s];
      for (int i = 0; i < SLOTS; i++)
        if (slot_valid[i] && slot_age[i] < a) slot_age[i]++;
      slot_age[s] = 0;
    endfunction

    function void insert_entry(logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
      int unsigned limit;
      int          oldest;
      int          free_slot;
      limit = (capacity == 0) ? 1 : ((capacity > SLOTS) ? SLOTS : capacity);
      if (occupancy >= limit) begin
        oldest = -1;
        for (int i = 0; i < SLOTS; i++)
          if (slot_valid[i] && (oldest < 0 || slot_age[i] > slot_age[oldest])) oldest = i;
        if (oldest >= 0) begin
          slot_valid[oldest] = 1'b0;
          slot_age[oldest] = 0;
          if (occupancy > 0) occupancy--;
        end
      end
      free_slot = -1;
      for (int i = 0; i < SLOTS; i++)
        if (!slot_valid[i] && free_slot < 0) free_slot = i;
      if (free_slot < 0) return;
      for (int i = 0; i < SLOTS; i++)
        if (slot_valid[i]) slot_age[i]++;
      slot_valid[free_slot] = 1'b1;
      slot_key[free_slot] = k;
      slot_value[free_slot] = v;
      slot_age[free_slot] = 0;
      occupancy++;
    endfunction

    function void record_request(logic req_type, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
      int     found;
      reply_t r;
      found = -1;
      for (int i = 0; i < SLOTS; i++)
        if (slot_valid[i] && slot_key[i] == k && found < 0) found = i;
      if (req_type == REQ_PUT) begin
        if (found >= 0) begin
          slot_value[found] = v;
          promote(found);
        end else begin
          insert_entry(k, v);
        end
        r.hit = (found >= 0);
        r.read_value = v;
      end else if (found >= 0) begin
        promote(found);
        r.hit = 1'b1;
        r.read_value = slot_value[found];
      end else begin
        r.hit = 1'b0;
        r.read_value = MISS_VALUE;
      end
      pending_replies.push_back(r);
    endfunction

    function void check_reply(logic hit, logic [VAL_W-1:0] read_value);
      reply_t want;
      if (pending_replies.size() == 0) begin
        mismatches++;
        $display("%0t: word with none expected, expected nothing, actual hit=%0b read_value=%h",
                 $time, hit, read_value);
        return;
      end
      want = pending_replies.pop_front();
      if (hit !== want.hit) begin
        mismatches++;
        $display("%0t: hit mismatch, expected %0b, actual %0b", $time, want.hit, hit);
      end
      if (read_value !== want.read_value) begin
        mismatches++;
        $display("%0t: read_value mismatch, expected %h, actual %h",
                 $time, want.read_value, read_value);
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_data;

  lkvc_req_if req_bus();
  lkvc_rsp_if rsp_bus();

  lru_cache_scoreboard board;
  int                  rsp_hold_req;
  bit                  sender_idles;
  bit                  receiver_stalls;

  lru_key_value_cache dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (req_bus),
    .out_ch  (rsp_bus),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_lru_key_value_cache failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(logic t, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    int gap;
    req_bus.valid <= 1'b1;
    req_bus.req_type <= t;
    req_bus.key <= k;
    req_bus.value <= v;
    do @(posedge clk); while (!req_bus.ready);
    board.record_request(t, k, v);
    @(negedge clk);
    gap = sender_idles ? pick_gap() : 0;
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain_replies();
    req_bus.valid <= 1'b0;
    while (board.pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] c);
    cfg_we <= 1'b1;
    cfg_data <= c;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.set_capacity(c);
  endtask

  task automatic random_phase(int n, int pool_n);
    logic [KEY_W-1:0] pool [$];
    logic [KEY_W-1:0] k;
    logic             t;
    for (int i = 0; i < pool_n; i++) pool.push_back($urandom);
    for (int i = 0; i < n; i++) begin
      k = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, pool_n - 1)] : $urandom;
      t = ($urandom_range(0, 1) == 1) ? REQ_PUT : REQ_GET;
      send_word(t, k, $urandom);
    end
  endtask

  initial begin : reply_sink
    int stall_left;
    stall_left = 0;
    rsp_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (rsp_hold_req > 0) begin
        stall_left = rsp_hold_req;
        rsp_hold_req = 0;
      end
      if (stall_left > 0) begin
        rsp_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_bus.ready <= 1'b1;
        if (receiver_stalls && $urandom_range(0, 99) < 30) stall_left = pick_gap();
      end
      @(posedge clk);
      if (rsp_bus.valid && rsp_bus.ready) board.check_reply(rsp_bus.hit, rsp_bus.read_value);
    end
  end

  initial begin : stimulus
    logic [CAP_W-1:0] phase_caps [10];
    int eff;
    phase_caps = '{5'd1, 5'd0, 5'd31, 5'd5, 5'd17,
                   5'd3, 5'd8, 5'd16, 5'd24, 5'd2};
    board = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    req_bus.valid = 1'b0;
    req_bus.req_type = REQ_GET;
    req_bus.key = '0;
    req_bus.value = '0;
    sender_idles = 1'b1;
    receiver_stalls = 1'b1;
    rsp_hold_req = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_word(REQ_GET, 32'h0000_0000, 32'h1234_5678);
    send_word(REQ_PUT, 32'h8000_0000, 32'h7fff_ffff);
    send_word(REQ_PUT, 32'h7fff_ffff, 32'h8000_0000);
    send_word(REQ_GET, 32'h8000_0000, 32'hffff_ffff);
    send_word(REQ_GET, 32'h7fff_ffff, 32'h0000_0000);
    send_word(REQ_PUT, 32'h8000_0000, 32'hffff_ffff);
    send_word(REQ_GET, 32'hffff_ffff, 32'h0000_0000);
    send_word(REQ_PUT, 32'hffff_ffff, 32'h0000_0000);
    send_word(REQ_GET, 32'hffff_ffff, 32'h5a5a_5a5a);
    send_word(REQ_GET, 32'h0000_0000, 32'ha5a5_a5a5);
    for (int i = 1; i <= 13; i++) send_word(REQ_PUT, i, $urandom);
    send_word(REQ_PUT, 32'd100, 32'h0bad_cafe);
    send_word(REQ_GET, 32'h7fff_ffff, 32'h0000_0000);
    drain_replies();

    write_capacity(5'd2);
    send_word(REQ_PUT, 32'h5555_aaaa, 32'h0000_0001);
    send_word(REQ_PUT, 32'haaaa_5555, 32'h0000_0002);
    send_word(REQ_GET, 32'h0000_0001, 32'h0000_0000);
    send_word(REQ_GET, 32'h5555_aaaa, 32'h0000_0000);
    drain_replies();

    for (int p = 0; p < 10; p++) begin
      write_capacity(phase_caps[p]);
      eff = (phase_caps[p] == 0) ? 1 : ((phase_caps[p] > SLOTS) ? SLOTS : phase_caps[p]);
      sender_idles = (p % 4 == 0 || p % 4 == 2);
      receiver_stalls = (p % 4 == 0 || p % 4 == 3);
      if (p == 3 || p == 7) rsp_hold_req = 300;
      random_phase(70, eff + $urandom_range(1, 6));
      drain_replies();
    end

    if (board.mismatches == 0 && board.pending_replies.size() == 0) begin
      $display("tb_lru_key_value_cache passed");
    end else begin
      $display("tb_lru_key_value_cache failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/lkvc_pkg.sv
hdl/lkvc_if.sv
hdl/lkvc_tag_store.sv
hdl/lru_key_value_cache.sv
test/tb_lru_key_value_cache.sv
